@@ rtl/ldt_pkg.sv @@
// ----------------------------------------------------------------------------
// ldt_pkg
// shared widths, command codes, register indexes and reset values for the
// link discovery timers
// ----------------------------------------------------------------------------
`default_nettype none

package ldt_pkg;

   localparam int CMD_W     = 3;
   localparam int ELAPSED_W = 32;
   localparam int LIMIT_W   = 48;
   localparam int COUNT_W   = LIMIT_W + 1;
   localparam int CSR_IDX_W = 2;

   // command codes
   localparam logic [CMD_W-1:0] CMD_TICK     = 3'd0;
   localparam logic [CMD_W-1:0] CMD_LINKED   = 3'd1;
   localparam logic [CMD_W-1:0] CMD_UNLINKED = 3'd2;
   localparam logic [CMD_W-1:0] CMD_CONN_GO  = 3'd3;
   localparam logic [CMD_W-1:0] CMD_CONN_END = 3'd4;
   localparam logic [CMD_W-1:0] CMD_RESCAN   = 3'd5;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_DISCOVERY = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_CONNECT   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_RESCAN    = 2'd2;

   // register reset values, ns
   localparam logic [LIMIT_W-1:0] DISCOVERY_RST = 48'd10000000000;
   localparam logic [LIMIT_W-1:0] CONNECT_RST   = 48'd5000000000;
   localparam logic [LIMIT_W-1:0] RESCAN_RST    = 48'd1000000000;

endpackage

`default_nettype wire

@@ rtl/link_discovery_timers_unit.sv @@
// ----------------------------------------------------------------------------
// link_discovery_timers_unit
// discovery watchdog, connect timeout and rescan delay timers driven by link
// events and elapsed-time ticks
// ----------------------------------------------------------------------------
// An item is a command (tick, linked, unlinked, connect started, connect
// resolved, rescan request) with an elapsed time in ns used by ticks only.
// Each tick gives exactly one result carrying the three expiry flags; every
// other command gives none. The block takes one item per cycle while the
// input register is not held: an accepted item is captured in the input
// register, is applied to the timer state by three parallel 49-bit
// add-and-compare paths, and a tick's flags land in the output register as
// the tick is applied. Input and output are parted by that output register,
// so new items keep flowing while a result waits; only a tick that finds the
// output register full and not being taken holds the input register.
// Threshold registers are written through the csr port, which is always
// ready; writes are meant to happen while no item is in flight.
`default_nettype none

module link_discovery_timers_unit (
   input  logic                          clock,
   input  logic                          reset,
   // configuration write
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [ldt_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [ldt_pkg::LIMIT_W-1:0]   csr_data,
   // items in
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [ldt_pkg::CMD_W-1:0]     req_cmd,
   input  logic [ldt_pkg::ELAPSED_W-1:0] req_elapsed_ns,
   // results out
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_go_symmetric,
   output logic                          rsp_abort_connect,
   output logic                          rsp_do_rescan
);

   import ldt_pkg::*;

   // threshold registers
   logic [LIMIT_W-1:0] disc_limit_ff, conn_limit_ff, rescan_limit_ff;

   // input register
   logic                 s1_valid_ff;
   logic [CMD_W-1:0]     s1_cmd_ff;
   logic [ELAPSED_W-1:0] s1_elapsed_ff;

   // timer state
   logic               link_up_ff, link_up_in;
   logic               disc_armed_ff, disc_armed_in;
   logic               conn_armed_ff, conn_armed_in;
   logic               rescan_armed_ff, rescan_armed_in;
   logic [COUNT_W-1:0] disc_count_ff, disc_count_in;
   logic [COUNT_W-1:0] conn_count_ff, conn_count_in;
   logic [COUNT_W-1:0] rescan_count_ff, rescan_count_in;

   // output register
   logic rsp_valid_ff;
   logic go_sym_ff, go_sym_in;
   logic abort_ff, abort_in;
   logic rescan_ff, rescan_in;

   logic s1_is_tick, s1_fire, rsp_free;
   logic [COUNT_W-1:0] disc_sum, conn_sum, rescan_sum;
   logic disc_hit, conn_hit, rescan_hit;

   // ---------------------------------------------------------------- handshakes
   assign csr_ready  = 1'b1;
   assign s1_is_tick = (s1_cmd_ff == CMD_TICK);
   assign rsp_free   = !rsp_valid_ff || rsp_ready;
   // non-tick commands never need the output register
   assign s1_fire    = s1_valid_ff && (!s1_is_tick || rsp_free);
   assign req_ready  = !s1_valid_ff || s1_fire;

   // ---------------------------------------------------------------- config
   always_ff @(posedge clock) begin
      if (reset) begin
         disc_limit_ff   <= DISCOVERY_RST;
         conn_limit_ff   <= CONNECT_RST;
         rescan_limit_ff <= RESCAN_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_DISCOVERY: disc_limit_ff   <= csr_data;
            REG_CONNECT:   conn_limit_ff   <= csr_data;
            REG_RESCAN:    rescan_limit_ff <= csr_data;
            default: ;     // unused index, write dropped
         endcase
      end
   end

   // ---------------------------------------------------------------- input register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ready) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_cmd_ff     <= req_cmd;
         s1_elapsed_ff <= req_elapsed_ns;
      end
   end

   // ---------------------------------------------------------------- timer datapath
   // a running counter stays below its 48-bit threshold, so 49 bits never wrap
   assign disc_sum   = disc_count_ff + COUNT_W'(s1_elapsed_ff);
   assign conn_sum   = conn_count_ff + COUNT_W'(s1_elapsed_ff);
   assign rescan_sum = rescan_count_ff + COUNT_W'(s1_elapsed_ff);

   assign disc_hit   = disc_armed_ff   && (disc_sum   >= COUNT_W'(disc_limit_ff));
   assign conn_hit   = conn_armed_ff   && (conn_sum   >= COUNT_W'(conn_limit_ff));
   assign rescan_hit = rescan_armed_ff && (rescan_sum >= COUNT_W'(rescan_limit_ff));

   always_comb begin
      link_up_in      = link_up_ff;
      disc_armed_in   = disc_armed_ff;
      conn_armed_in   = conn_armed_ff;
      rescan_armed_in = rescan_armed_ff;
      disc_count_in   = disc_count_ff;
      conn_count_in   = conn_count_ff;
      rescan_count_in = rescan_count_ff;
      go_sym_in       = disc_hit;
      abort_in        = conn_hit;
      rescan_in       = rescan_hit;
      case (s1_cmd_ff)
         CMD_TICK: begin
            // watchdog is periodic and rearms from zero
            if (disc_armed_ff) begin
               disc_count_in = disc_hit ? '0 : disc_sum;
            end
            // one-shots disarm on expiry
            if (conn_armed_ff) begin
               conn_count_in = conn_hit ? '0 : conn_sum;
               conn_armed_in = !conn_hit;
            end
            if (rescan_armed_ff) begin
               rescan_count_in = rescan_hit ? '0 : rescan_sum;
               rescan_armed_in = !rescan_hit;
            end
         end
         CMD_LINKED: begin
            link_up_in      = 1'b1;
            disc_armed_in   = 1'b0;
            conn_armed_in   = 1'b0;
            rescan_armed_in = 1'b0;
            disc_count_in   = '0;
            conn_count_in   = '0;
            rescan_count_in = '0;
         end
         CMD_UNLINKED: begin
            link_up_in    = 1'b0;
            disc_armed_in = 1'b1;
            disc_count_in = '0;
         end
         CMD_CONN_GO: begin
            conn_armed_in = 1'b1;
            conn_count_in = '0;
         end
         CMD_CONN_END: begin
            conn_armed_in = 1'b0;
            conn_count_in = '0;
         end
         CMD_RESCAN: begin
            // ignored while linked, pending rescan kept
            if (!link_up_ff) begin
               rescan_armed_in = 1'b1;
               rescan_count_in = '0;
            end
         end
         default: ;  // unused codes change nothing
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         link_up_ff      <= 1'b0;
         disc_armed_ff   <= 1'b0;
         conn_armed_ff   <= 1'b0;
         rescan_armed_ff <= 1'b0;
         disc_count_ff   <= '0;
         conn_count_ff   <= '0;
         rescan_count_ff <= '0;
      end else if (s1_fire) begin
         link_up_ff      <= link_up_in;
         disc_armed_ff   <= disc_armed_in;
         conn_armed_ff   <= conn_armed_in;
         rescan_armed_ff <= rescan_armed_in;
         disc_count_ff   <= disc_count_in;
         conn_count_ff   <= conn_count_in;
         rescan_count_ff <= rescan_count_in;
      end
   end

   // ---------------------------------------------------------------- output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_fire && s1_is_tick) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_fire && s1_is_tick) begin
         go_sym_ff <= go_sym_in;
         abort_ff  <= abort_in;
         rescan_ff <= rescan_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_go_symmetric  = go_sym_ff;
   assign rsp_abort_connect = abort_ff;
   assign rsp_do_rescan     = rescan_ff;

   // ---------------------------------------------------------------- assertions
`ifndef SYNTHESIS
   // every processed tick leaves a result in the output register
   a_tick_gives_result: assert property (@(posedge clock) disable iff (reset)
      s1_fire && s1_is_tick |=> rsp_valid_ff)
      else $error("tick processed without a result");

   // a linked event leaves all timers disarmed
   a_linked_disarms: assert property (@(posedge clock) disable iff (reset)
      s1_fire && (s1_cmd_ff == CMD_LINKED) |=>
         !disc_armed_ff && !conn_armed_ff && !rescan_armed_ff)
      else $error("timer still armed after linked");

   // a disarmed one-shot holds a cleared counter
   a_conn_idle_zero: assert property (@(posedge clock) disable iff (reset)
      !conn_armed_ff |-> (conn_count_ff == '0))
      else $error("connect counter nonzero while disarmed");

   a_rescan_idle_zero: assert property (@(posedge clock) disable iff (reset)
      !rescan_armed_ff |-> (rescan_count_ff == '0))
      else $error("rescan counter nonzero while disarmed");
`endif

endmodule

`default_nettype wire
